### src/fix_tag_value_extractor_core_macros.svh
// Assertion macros for the FIX tag value extractor.
`ifndef FIX_TAG_VALUE_EXTRACTOR_CORE_MACROS_SVH
`define FIX_TAG_VALUE_EXTRACTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define FTVE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ftve assertion failed");

// Check that at most one bit of a vector is set.
`define FTVE_ASSERT_ONEHOT0(name, clk, rstn, vec) \
  name: assert property (@(posedge clk) disable iff (!rstn) $onehot0(vec)) \
    else $error("ftve vector not one-hot");

`else

`define FTVE_ASSERT(name, clk, rstn, prop)
`define FTVE_ASSERT_ONEHOT0(name, clk, rstn, vec)

`endif

`endif

### src/ftve_pkg.sv
// Shared types and constants of the FIX tag value extractor.
`default_nettype none

package ftve_pkg;

  localparam int unsigned MaxTagCharsDef = 8;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TagCharsW = 64;
  localparam int unsigned TagLenW   = 4;
  localparam int unsigned ValLenW   = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [ByteW-1:0] DelimChar  = 8'h7C;
  localparam logic [ByteW-1:0] EqualsChar = 8'h3D;

  localparam logic [TagCharsW-1:0] TagCharsRst = 64'd12853;
  localparam logic [TagLenW-1:0]   TagLenRst   = 4'd2;
  localparam logic [ValLenW-1:0]   MaxValRst   = 8'd32;

  typedef enum logic [1:0] {
    KindByte     = 2'd0,
    KindLast     = 2'd1,
    KindEmptyEnd = 2'd2,
    KindNotFound = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTagChars       = 2'd0,
    CfgTagLength      = 2'd1,
    CfgMaxValueLength = 2'd2
  } cfg_idx_e;

  // Pattern byte seen by one matcher cell.
  typedef struct packed {
    logic [ByteW-1:0] chr;
    logic             vld;
    logic             last;
  } pat_t;

  // Per-item control handed to the extraction stage.
  typedef struct packed {
    logic             take;
    logic             eom;
    logic             found;
    logic [ByteW-1:0] data;
  } step_t;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   value_byte;
    logic [ValLenW-1:0] value_length;
  } res_t;

endpackage

`default_nettype wire

### src/ftve_if.sv
// Handshake channel interfaces: message bytes, results, configuration writes.
`default_nettype none

interface ftve_msg_if;
  logic                       valid;
  logic                       ready;
  logic [ftve_pkg::ByteW-1:0] msg_byte;
  logic                       end_of_message;

  modport source (output valid, msg_byte, end_of_message, input ready);
  modport sink (input valid, msg_byte, end_of_message, output ready);
endinterface

interface ftve_res_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [ftve_pkg::ByteW-1:0]   value_byte;
  logic [ftve_pkg::ValLenW-1:0] value_length;

  modport source (output valid, kind, value_byte, value_length, input ready);
  modport sink (input valid, kind, value_byte, value_length, output ready);
endinterface

interface ftve_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ftve_pkg::CfgIdxW-1:0]  index;
  logic [ftve_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/ftve_cell.sv
// One matcher cell: holds one pattern position and passes its hit to the next cell.
`default_nettype none

module ftve_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       shift_i,
  input  wire logic                       seed_i,
  input  wire logic                       hit_i,
  input  wire logic [ftve_pkg::ByteW-1:0] data_i,
  input  wire ftve_pkg::pat_t             pat_i,
  output logic                            active_o,
  output logic                            hit_o,
  output logic                            done_o
);

  logic active_q;
  logic active_d;

  always_comb begin
    active_d = active_q;
    if (step_i) begin
      active_d = shift_i ? hit_i : seed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  assign hit_o    = active_q && pat_i.vld && (data_i == pat_i.chr);
  assign done_o   = hit_o && pat_i.last;
  assign active_o = active_q;

endmodule

`default_nettype wire

### src/ftve_extract.sv
// Extraction stage: phase, value count and the result output register.
`default_nettype none

module ftve_extract (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ftve_pkg::step_t              step_i,
  input  wire logic [ftve_pkg::ValLenW-1:0] cap_i,
  input  wire logic                         out_ready_i,
  output logic                              in_ready_o,
  output logic                              scan_o,
  output logic                              out_valid_o,
  output ftve_pkg::res_t                    res_o
);

  typedef enum logic [1:0] {
    PhScan    = 2'd0,
    PhExtract = 2'd1,
    PhDone    = 2'd2
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [ftve_pkg::ValLenW-1:0] count_q, count_d;
  logic [ftve_pkg::ValLenW-1:0] count_inc;
  logic                         vld_q, vld_d;
  ftve_pkg::res_t               res_q, res_d;
  logic                         emit;

  assign count_inc = count_q + ftve_pkg::ValLenW'(1);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    emit    = 1'b0;
    res_d   = '{kind: ftve_pkg::KindByte, value_byte: '0, value_length: '0};
    if (step_i.take) begin
      case (phase_q)
        PhScan: begin
          if (step_i.found) begin
            count_d = '0;
            if (step_i.eom || (cap_i == '0)) begin
              emit       = 1'b1;
              res_d.kind = ftve_pkg::KindEmptyEnd;
              phase_d    = PhDone;
            end else begin
              phase_d = PhExtract;
            end
          end else if (step_i.eom) begin
            emit       = 1'b1;
            res_d.kind = ftve_pkg::KindNotFound;
          end
        end
        PhExtract: begin
          emit = 1'b1;
          if ((step_i.data == ftve_pkg::DelimChar) || (count_q >= cap_i)) begin
            res_d.kind         = ftve_pkg::KindEmptyEnd;
            res_d.value_length = count_q;
            phase_d            = PhDone;
          end else begin
            count_d            = count_inc;
            res_d.value_byte   = step_i.data;
            res_d.value_length = count_inc;
            if ((count_inc >= cap_i) || step_i.eom) begin
              res_d.kind = ftve_pkg::KindLast;
              phase_d    = PhDone;
            end
          end
        end
        default: ;
      endcase
      if (step_i.eom) begin
        phase_d = PhScan;
        count_d = '0;
      end
    end
  end

  assign vld_d = step_i.take ? emit : (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhScan;
      count_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.take && emit) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign scan_o      = (phase_q == PhScan);
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### src/fix_tag_value_extractor_core.sv
// Top level of the FIX tag value extractor: config registers, matcher chain, extraction.
// The block takes one message byte per cycle and gives its result, if any, from an
// output register; a byte is accepted whenever that register is empty or
// being read in the same cycle, so throughput is one byte per cycle while the result
// sink keeps up. Matching runs through a row of MaxTagChars+1 cells, one per pattern
// position after the leading '|', each comparing the incoming byte against its pattern
// character and passing its hit to the next cell. Configuration writes are always taken
// and must be made only while the block is idle.
`default_nettype none

`include "fix_tag_value_extractor_core_macros.svh"

module fix_tag_value_extractor_core #(
  parameter int unsigned MaxTagChars = ftve_pkg::MaxTagCharsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ftve_msg_if.sink   msg_i,
  ftve_res_if.source res_o,
  ftve_cfg_if.sink   cfg_i
);

  localparam int unsigned NumCells = MaxTagChars + 1;

  logic [ftve_pkg::TagCharsW-1:0] tag_chars_q;
  logic [ftve_pkg::TagLenW-1:0]   tag_len_q;
  logic [ftve_pkg::ValLenW-1:0]   cap_q;
  logic [ftve_pkg::TagLenW-1:0]   eff_len;
  logic [ftve_pkg::TagLenW-1:0]   eq_pos;

  logic                accept;
  logic                in_ready;
  logic                scan;
  logic                pos_zero;
  logic                hit_zero;
  logic                any_hit;
  logic                found;
  logic                shift;
  logic                restart;
  logic [NumCells-1:0] active;
  logic [NumCells-1:0] hit;
  logic [NumCells-1:0] done;
  logic [NumCells-1:0] hit_in;
  ftve_pkg::step_t     step;
  ftve_pkg::res_t      res;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_chars_q <= ftve_pkg::TagCharsRst;
      tag_len_q   <= ftve_pkg::TagLenRst;
      cap_q       <= ftve_pkg::MaxValRst;
    end else if (cfg_i.valid) begin
      case (ftve_pkg::cfg_idx_e'(cfg_i.index))
        ftve_pkg::CfgTagChars:       tag_chars_q <= cfg_i.data;
        ftve_pkg::CfgTagLength:      tag_len_q <= cfg_i.data[ftve_pkg::TagLenW-1:0];
        ftve_pkg::CfgMaxValueLength: cap_q <= cfg_i.data[ftve_pkg::ValLenW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate tag length to the number of tag cells.
  assign eff_len = (tag_len_q > ftve_pkg::TagLenW'(MaxTagChars)) ?
                   ftve_pkg::TagLenW'(MaxTagChars) : tag_len_q;
  assign eq_pos  = eff_len + ftve_pkg::TagLenW'(1);

  assign accept = msg_i.valid && in_ready;

  // Position zero is held implicitly: no cell active.
  assign pos_zero = ~|active;
  assign hit_zero = pos_zero && (msg_i.msg_byte == ftve_pkg::DelimChar);
  assign any_hit  = hit_zero || (|hit);
  assign found    = |done;
  assign shift    = scan && !msg_i.end_of_message && any_hit && !found;
  assign restart  = scan && !msg_i.end_of_message && !any_hit &&
                    (msg_i.msg_byte == ftve_pkg::DelimChar);

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    localparam logic [ftve_pkg::TagLenW-1:0] Pos = ftve_pkg::TagLenW'(c + 1);
    ftve_pkg::pat_t pat;
    logic           seed;

    if (c < MaxTagChars) begin : g_tag
      assign pat.chr = (Pos <= eff_len) ? tag_chars_q[8*c +: 8] : ftve_pkg::EqualsChar;
    end else begin : g_eq
      assign pat.chr = ftve_pkg::EqualsChar;
    end
    assign pat.vld  = (Pos <= eq_pos);
    assign pat.last = (Pos == eq_pos);

    if (c == 0) begin : g_first
      assign hit_in[c] = hit_zero;
      assign seed      = restart;
    end else begin : g_rest
      assign hit_in[c] = hit[c-1];
      assign seed      = 1'b0;
    end

    ftve_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (accept),
      .shift_i (shift),
      .seed_i  (seed),
      .hit_i   (hit_in[c]),
      .data_i  (msg_i.msg_byte),
      .pat_i   (pat),
      .active_o(active[c]),
      .hit_o   (hit[c]),
      .done_o  (done[c])
    );
  end

  assign step.take  = accept;
  assign step.eom   = msg_i.end_of_message;
  assign step.found = scan && found;
  assign step.data  = msg_i.msg_byte;

  ftve_extract u_extract (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cap_i      (cap_q),
    .out_ready_i(res_o.ready),
    .in_ready_o (in_ready),
    .scan_o     (scan),
    .out_valid_o(res_o.valid),
    .res_o      (res)
  );

  assign msg_i.ready        = in_ready;
  assign res_o.kind         = 2'(res.kind);
  assign res_o.value_byte   = res.value_byte;
  assign res_o.value_length = res.value_length;

  `FTVE_ASSERT_ONEHOT0(a_pos_onehot, clk_i, rst_ni, active)
  `FTVE_ASSERT(a_pos_idle, clk_i, rst_ni, !scan |-> pos_zero)
  `FTVE_ASSERT(a_eom_clear, clk_i, rst_ni, (accept && msg_i.end_of_message) |=> (scan && pos_zero))
  `FTVE_ASSERT(a_found_extract, clk_i, rst_ni, (accept && step.found && !msg_i.end_of_message && (cap_q != '0)) |=> !scan)

endmodule

`default_nettype wire

### tb/sv/fix_tag_value_extractor_core_tb.sv
// Testbench for the FIX tag value extractor: directed and random messages checked by a scoreboard.
module fix_tag_value_extractor_core_tb;
  import ftve_pkg::*;

  localparam int unsigned TotalItems   = 1400;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit  = 10;

  typedef enum logic [1:0] {
    ScanPhase    = 2'd0,
    ExtractPhase = 2'd1,
    DonePhase    = 2'd2
  } scan_state_e;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             eom;
  } msg_item_t;

  class value_tracker;
    res_t                 pending[$];
    logic [TagCharsW-1:0] tag_chars;
    logic [TagLenW-1:0]   tag_len;
    logic [ValLenW-1:0]   max_len;
    int unsigned          match_pos;
    scan_state_e          phase;
    logic [ValLenW-1:0]   count;
    int unsigned          failures;

    function new();
      tag_chars = TagCharsRst;
      tag_len   = TagLenRst;
      max_len   = MaxValRst;
      match_pos = 0;
      phase     = ScanPhase;
      count     = '0;
      failures  = 0;
    endfunction

    function res_t make_res(kind_e k, logic [ByteW-1:0] vb, logic [ValLenW-1:0] vl);
      res_t r;
      r.kind         = k;
      r.value_byte   = vb;
      r.value_length = vl;
      return r;
    endfunction

    function void report(string s);
      failures++;
      if (failures <= ReportLimit) $display("%s", s);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
      case (idx)
        CfgTagChars:       tag_chars = d;
        CfgTagLength:      tag_len   = d[TagLenW-1:0];
        CfgMaxValueLength: max_len   = d[ValLenW-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [ByteW-1:0] b, logic eom);
      int unsigned eff;
      int unsigned plen;
      int unsigned j;
      logic [ByteW:0] want;
      res_t r;
      bit emit;
      emit = 1'b0;
      r    = make_res(KindNotFound, '0, '0);
      eff  = (tag_len > MaxTagCharsDef) ? MaxTagCharsDef : tag_len;
      plen = eff + 2;
      case (phase)
        ScanPhase: begin
          j = match_pos;
          if (j == 0) want = {1'b0, DelimChar};
          else if (j <= eff) want = {1'b0, tag_chars[8*(j-1) +: 8]};
          else if (j == eff + 1) want = {1'b0, EqualsChar};
          else want = 9'h100;
          if (j < plen && {1'b0, b} == want) j++;
          else j = (b == DelimChar) ? 1 : 0;
          if (j >= plen) begin
            match_pos = 0;
            count     = '0;
            if (eom || max_len == 0) begin
              r     = make_res(KindEmptyEnd, '0, '0);
              emit  = 1'b1;
              phase = DonePhase;
            end else begin
              phase = ExtractPhase;
            end
          end else begin
            match_pos = j;
            if (eom) begin
              r    = make_res(KindNotFound, '0, '0);
              emit = 1'b1;
            end
          end
        end
        ExtractPhase: begin
          if (b == DelimChar || count >= max_len) begin
            r     = make_res(KindEmptyEnd, '0, count);
            emit  = 1'b1;
            phase = DonePhase;
          end else begin
            count++;
            emit = 1'b1;
            if (count >= max_len || eom) begin
              r     = make_res(KindLast, b, count);
              phase = DonePhase;
            end else begin
              r = make_res(KindByte, b, count);
            end
          end
        end
        default: ;
      endcase
      if (eom) begin
        match_pos = 0;
        phase     = ScanPhase;
        count     = '0;
      end
      if (emit) pending = {pending, r};
    endfunction

    function void check_result(logic [1:0] kind, logic [ByteW-1:0] vb, logic [ValLenW-1:0] vl);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d byte %02h length %0d",
                         kind, vb, vl));
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind || vb !== want.value_byte || vl !== want.value_length)
        report($sformatf("expected kind %0d byte %02h len %0d, got kind %0d byte %02h len %0d",
                         want.kind, want.value_byte, want.value_length, kind, vb, vl));
    endfunction

    function void close();
      if (pending.size() != 0)
        report($sformatf("%0d expected results never arrived", pending.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ftve_msg_if msg_ch ();
  ftve_res_if res_ch ();
  ftve_cfg_if cfg_ch ();

  fix_tag_value_extractor_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .msg_i  (msg_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  value_tracker tracker = new();

  msg_item_t            stim_q[$];
  int unsigned          items_sent = 0;
  bit                   idle_on = 1'b1;
  bit                   hold_req = 1'b0;
  logic [TagCharsW-1:0] cur_tag = TagCharsRst;
  logic [TagLenW-1:0]   cur_len = TagLenRst;
  logic [ValLenW-1:0]   cur_cap = MaxValRst;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready)
        tracker.check_result(res_ch.kind, res_ch.value_byte, res_ch.value_length);
      if (msg_ch.valid && msg_ch.ready)
        tracker.note_byte(msg_ch.msg_byte, msg_ch.end_of_message);
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.set_reg(cfg_idx_e'(cfg_ch.index), cfg_ch.data);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int unsigned stall;
    int unsigned hold_left;
    stall     = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic push_item(input logic [ByteW-1:0] b, input bit eom);
    msg_item_t it;
    it.b   = b;
    it.eom = eom;
    stim_q = {stim_q, it};
  endtask

  task automatic push_text(input string s, input bit eom_last);
    for (int i = 0; i < s.len(); i++)
      push_item(8'(s[i]), eom_last && (i == s.len() - 1));
  endtask

  task automatic add_message(input bit well_formed);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] vb;
    int unsigned eff;
    int unsigned nf;
    int unsigned n;
    int unsigned vmax;
    eff = (cur_len > MaxTagCharsDef) ? MaxTagCharsDef : cur_len;
    if (!well_formed) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       body = {body, DelimChar};
          1:       body = {body, cur_tag[8*$urandom_range(0, 7) +: 8]};
          default: body = {body, 8'($urandom_range(0, 255))};
        endcase
      end
    end else begin
      nf = $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) body = {body, DelimChar};
      for (int f = 0; f < nf; f++) begin
        if ($urandom_range(0, 2) == 0) begin
          for (int k = 0; k < eff; k++) body = {body, cur_tag[8*k +: 8]};
        end else if (eff > 1 && $urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, eff - 1);
          for (int k = 0; k < n; k++) body = {body, cur_tag[8*k +: 8]};
        end else begin
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++) body = {body, 8'($urandom_range(48, 57))};
        end
        body = {body, EqualsChar};
        vmax = ($urandom_range(0, 29) == 0) ? cur_cap + 2 : ((cur_cap < 9) ? cur_cap + 1 : 10);
        n = $urandom_range(0, vmax);
        for (int k = 0; k < n; k++) begin
          vb = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(32, 126));
          if (vb == DelimChar) vb = 8'h41;
          body = {body, vb};
        end
        body = {body, DelimChar};
      end
      if ($urandom_range(0, 3) == 0) body = body[0:$urandom_range(0, body.size() - 1)];
    end
    for (int i = 0; i < body.size(); i++) push_item(body[i], i == body.size() - 1);
  endtask

  task automatic send_bytes();
    msg_item_t it;
    int unsigned gap;
    while (stim_q.size() > 0) begin
      it  = stim_q.pop_front();
      gap = pick_gap();
      if (gap > 0) begin
        msg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      msg_ch.valid          <= 1'b1;
      msg_ch.msg_byte       <= it.b;
      msg_ch.end_of_message <= it.eom;
      do @(posedge clk); while (!msg_ch.ready);
      items_sent++;
    end
    msg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [TagCharsW-1:0] tag, input logic [TagLenW-1:0] len,
                            input logic [ValLenW-1:0] cap);
    cfg_idx_e idx;
    for (int i = 0; i < 3; i++) begin
      idx = cfg_idx_e'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      case (idx)
        CfgTagChars:  cfg_ch.data <= tag;
        CfgTagLength: cfg_ch.data <= CfgDataW'(len);
        default:      cfg_ch.data <= CfgDataW'(cap);
      endcase
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_tag = tag;
    cur_len = len;
    cur_cap = cap;
  endtask

  task automatic run_phase(input logic [TagCharsW-1:0] tag, input logic [TagLenW-1:0] len,
                           input logic [ValLenW-1:0] cap, input int unsigned n_items,
                           input bit idle, input bit pressure);
    wait_idle();
    write_regs(tag, len, cap);
    idle_on = idle;
    while (stim_q.size() < n_items) add_message($urandom_range(0, 4) != 0);
    if (pressure) hold_req = 1'b1;
    send_bytes();
  endtask

  initial begin
    logic [TagCharsW-1:0] rtag;
    logic [TagLenW-1:0]   rlen;
    logic [ValLenW-1:0]   rcap;
    logic [ByteW-1:0]     vb;
    msg_ch.valid          <= 1'b0;
    msg_ch.msg_byte       <= '0;
    msg_ch.end_of_message <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CfgTagChars;
    cfg_ch.data           <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_text("52=x", 1'b1);
    push_text("|52=", 1'b1);
    push_text("|52=||", 1'b1);
    push_text("|52=A", 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b1);
    push_text("|5|52=Q|", 1'b1);
    send_bytes();

    push_text("|35=", 1'b0);
    for (int i = 0; i < 258; i++) begin
      vb = 8'($urandom_range(32, 126));
      if (vb == DelimChar) vb = 8'h7E;
      push_item(vb, i == 257);
    end
    run_phase(64'h3533, 4'd2, 8'd255, 460, 1'b1, 1'b0);
    run_phase(64'h3231474154584946, 4'd8, 8'd1, 400, 1'b0, 1'b1);
    run_phase(64'h38, 4'd1, 8'd3, 150, 1'b1, 1'b0);
    push_text("a|=b", 1'b1);
    run_phase(64'h0, 4'd0, 8'd0, 100, 1'b1, 1'b0);
    run_phase({TagCharsW{1'b1}}, 4'd12, 8'd7, 100, 1'b1, 1'b0);
    run_phase(64'h0, 4'd8, 8'd128, 100, 1'b0, 1'b0);

    while (items_sent < TotalItems) begin
      for (int k = 0; k < 8; k++)
        rtag[8*k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(48, 57));
      rlen = 4'($urandom_range(1, 8));
      rcap = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(1, 40));
      run_phase(rtag, rlen, rcap, 150, $urandom_range(0, 3) != 0, 1'b0);
    end

    wait_idle();
    tracker.close();
    if (tracker.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
